@@ design/p1305_pkg.sv @@
// Poly1305 MAC package: limb constants, clamp masks, register indexes,
// controller state type and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package p1305_pkg;

   localparam int LIMB_W = 26;
   localparam int NUM_LIMBS = 5;
   localparam int COL_W = 3;
   localparam int CSR_IDX_W = 2;
   localparam int KEY_W = 64;
   localparam int HIBIT_POS = 24;
   localparam logic [4:0] FULL_BYTES = 5'd16;

   localparam logic [LIMB_W-1:0] CLAMP0 = 26'h3ffffff;
   localparam logic [LIMB_W-1:0] CLAMP1 = 26'h3ffff03;
   localparam logic [LIMB_W-1:0] CLAMP2 = 26'h3ffc0ff;
   localparam logic [LIMB_W-1:0] CLAMP3 = 26'h3f03fff;
   localparam logic [LIMB_W-1:0] CLAMP4 = 26'h00fffff;

   localparam logic [COL_W-1:0] LAST_COL = 3'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KEY_R_LOW  = 2'd0,
      REG_KEY_R_HIGH = 2'd1,
      REG_KEY_S_LOW  = 2'd2,
      REG_KEY_S_HIGH = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_SUM,
      ST_WRAP,
      ST_FIN1,
      ST_FIN2,
      ST_FIN3,
      ST_BAD
   } state_type;

   typedef struct packed {
      logic             capture;
      logic             load;
      logic             mul_en;
      logic [COL_W-1:0] mul_col;
      logic             wrap;
      logic             fin1;
      logic             fin2;
      logic             out_write;
      logic             out_bad;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ design/p1305_ctrl.sv @@
// Poly1305 MAC controller: sequences capture, load, column multiply,
// carry wrap, final reduction, result write and bad-input response. Depends on p1305_pkg.
`default_nettype none

module p1305_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire  [4:0]             req_byte_count,
   input  wire                    req_is_last,
   output p1305_pkg::cmd_type     cmd,
   input  wire p1305_pkg::status_type sts
);
   import p1305_pkg::*;

   state_type        state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             fin_ff, fin_in;
   logic             accept;
   logic             full;

   assign accept = req_valid && req_ready;
   assign full   = req_byte_count >= FULL_BYTES;

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      fin_in   = fin_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fin_in = req_is_last;
               priority if (!req_is_last && !full) begin
                  state_in = ST_BAD;
               end else if (req_byte_count == '0) begin
                  state_in = ST_FIN1;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_MUL;
            col_in   = '0;
         end
         ST_MUL: begin
            if (col_ff == LAST_COL) begin
               state_in = ST_SUM;
            end else begin
               col_in = col_ff + 3'd1;
            end
         end
         ST_SUM:  state_in = ST_WRAP;
         ST_WRAP: state_in = fin_ff ? ST_FIN1 : ST_IDLE;
         ST_FIN1: state_in = ST_FIN2;
         ST_FIN2: state_in = ST_FIN3;
         ST_FIN3: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_BAD: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.mul_col   = col_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = accept;
         end
         ST_LOAD: cmd.load = 1'b1;
         ST_MUL:  cmd.mul_en = 1'b1;
         ST_SUM:  ;
         ST_WRAP: cmd.wrap = 1'b1;
         ST_FIN1: cmd.fin1 = 1'b1;
         ST_FIN2: cmd.fin2 = 1'b1;
         ST_FIN3: cmd.out_write = sts.out_free;
         ST_BAD: begin
            cmd.out_write = sts.out_free;
            cmd.out_bad   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

`default_nettype wire

@@ design/p1305_dp.sv @@
// Poly1305 MAC datapath: key registers, block capture and padding, 26-bit limb
// accumulator, five-lane column multiplier, final reduction and result register.
// Depends on p1305_pkg.
`default_nettype none

module p1305_dp (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_wr_en,
   input  wire  [p1305_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [p1305_pkg::KEY_W-1:0]     csr_wdata,
   input  wire  [63:0]                     req_block_low,
   input  wire  [63:0]                     req_block_high,
   input  wire  [4:0]                      req_byte_count,
   input  wire p1305_pkg::cmd_type         cmd,
   output p1305_pkg::status_type           sts,
   input  wire                             rsp_ready,
   output logic                            rsp_valid,
   output logic [63:0]                     rsp_tag_low,
   output logic [63:0]                     rsp_tag_high,
   output logic                            rsp_bad_input
);
   import p1305_pkg::*;

   logic [KEY_W-1:0]  key_ff [4];
   logic [127:0]      msg_ff;
   logic              top_ff;
   logic [26:0]       acc_ff [NUM_LIMBS];
   logic [27:0]       h_ff [NUM_LIMBS];
   logic [25:0]       r_ff [NUM_LIMBS];
   logic [28:0]       s5_ff [NUM_LIMBS];
   logic [56:0]       prod_ff [NUM_LIMBS];
   logic              prod_vld_ff;
   logic [COL_W-1:0]  prod_col_ff;
   logic [31:0]       carry_ff;
   logic [26:0]       fin_ff [NUM_LIMBS];
   logic [63:0]       lo_ff, hi_ff;
   logic              rsp_valid_ff;
   logic [63:0]       tag_low_ff, tag_high_ff;
   logic              bad_ff;

   logic [127:0]      blk, padded;
   logic              full;
   logic [25:0]       ml [NUM_LIMBS];
   logic [25:0]       rl [NUM_LIMBS];
   logic [25:0]       rc [NUM_LIMBS];
   logic [25:0]       clamp [NUM_LIMBS];
   logic [28:0]       coef [NUM_LIMBS];
   logic [63:0]       dsum;
   logic [31:0]       cin;
   logic [31:0]       wrap_t;
   logic [31:0]       a0, a1, a2, a3, a4, t2, t3, t4, t0, c1, c2, c3, c4, c0;
   logic [31:0]       g0, g1, g2, g3, g4, k0, k1, k2, k3;
   logic [31:0]       e0, e1, e2, e3, e4;
   logic              sel_g;
   logic [63:0]       lo_c, hi_c;
   logic [64:0]       sum_lo;
   logic [63:0]       sum_hi;

   assign clamp[0] = CLAMP0;
   assign clamp[1] = CLAMP1;
   assign clamp[2] = CLAMP2;
   assign clamp[3] = CLAMP3;
   assign clamp[4] = CLAMP4;

   // pad short block: keep valid bytes, append 0x01, zero the rest
   assign blk  = {req_block_high, req_block_low};
   assign full = req_byte_count >= FULL_BYTES;

   always_comb begin
      for (int j = 0; j < 16; j++) begin
         if (full || (5'(j) < req_byte_count)) begin
            padded[8*j +: 8] = blk[8*j +: 8];
         end else if (5'(j) == req_byte_count) begin
            padded[8*j +: 8] = 8'h01;
         end else begin
            padded[8*j +: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      ml[0] = msg_ff[25:0];
      ml[1] = msg_ff[51:26];
      ml[2] = msg_ff[77:52];
      ml[3] = msg_ff[103:78];
      ml[4] = {2'b00, msg_ff[127:104]};
      rl[0] = key_ff[REG_KEY_R_LOW][25:0];
      rl[1] = key_ff[REG_KEY_R_LOW][51:26];
      rl[2] = {key_ff[REG_KEY_R_HIGH][13:0], key_ff[REG_KEY_R_LOW][63:52]};
      rl[3] = key_ff[REG_KEY_R_HIGH][39:14];
      rl[4] = {2'b00, key_ff[REG_KEY_R_HIGH][63:40]};
      for (int i = 0; i < NUM_LIMBS; i++) begin
         rc[i] = rl[i] & clamp[i];
      end
   end

   // column k: h[i] * r[k-i], wrapping terms use 5*r
   always_comb begin
      for (int i = 0; i < NUM_LIMBS; i++) begin
         if (cmd.mul_col >= 3'(i)) begin
            coef[i] = {3'b000, r_ff[cmd.mul_col - 3'(i)]};
         end else begin
            coef[i] = s5_ff[cmd.mul_col + 3'(NUM_LIMBS - i)];
         end
      end
   end

   assign cin  = (prod_col_ff == '0) ? '0 : carry_ff;
   assign dsum = 64'(prod_ff[0]) + 64'(prod_ff[1]) + 64'(prod_ff[2]) + 64'(prod_ff[3])
               + 64'(prod_ff[4]) + 64'(cin);

   assign wrap_t = 32'(acc_ff[0]) + (carry_ff << 2) + carry_ff;

   // final carry pass
   always_comb begin
      a0 = 32'(acc_ff[0]);
      a1 = 32'(acc_ff[1]);
      a2 = 32'(acc_ff[2]);
      a3 = 32'(acc_ff[3]);
      a4 = 32'(acc_ff[4]);
      c1 = a1 >> LIMB_W;
      t2 = a2 + c1;
      c2 = t2 >> LIMB_W;
      t3 = a3 + c2;
      c3 = t3 >> LIMB_W;
      t4 = a4 + c3;
      c4 = t4 >> LIMB_W;
      t0 = a0 + (c4 << 2) + c4;
      c0 = t0 >> LIMB_W;
   end

   // conditional subtract of 2^130-5 and repack
   always_comb begin
      g0 = 32'(fin_ff[0]) + 32'd5;
      k0 = g0 >> LIMB_W;
      g1 = 32'(fin_ff[1]) + k0;
      k1 = g1 >> LIMB_W;
      g2 = 32'(fin_ff[2]) + k1;
      k2 = g2 >> LIMB_W;
      g3 = 32'(fin_ff[3]) + k2;
      k3 = g3 >> LIMB_W;
      g4 = 32'(fin_ff[4]) + k3 - 32'h0400_0000;
      sel_g = ~g4[31];
      e0 = sel_g ? 32'(g0[25:0]) : 32'(fin_ff[0]);
      e1 = sel_g ? 32'(g1[25:0]) : 32'(fin_ff[1]);
      e2 = sel_g ? 32'(g2[25:0]) : 32'(fin_ff[2]);
      e3 = sel_g ? 32'(g3[25:0]) : 32'(fin_ff[3]);
      e4 = sel_g ? g4 : 32'(fin_ff[4]);
      lo_c = 64'(e0) | (64'(e1) << 26) | (64'(e2) << 52);
      hi_c = (64'(e2) >> 12) | (64'(e3) << 14) | (64'(e4) << 40);
   end

   assign sum_lo = {1'b0, lo_ff} + {1'b0, key_ff[REG_KEY_S_LOW]};
   assign sum_hi = hi_ff + key_ff[REG_KEY_S_HIGH] + 64'(sum_lo[64]);

   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LIMBS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (cmd.fin2) begin
         for (int i = 0; i < NUM_LIMBS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (prod_vld_ff) begin
         acc_ff[prod_col_ff] <= {1'b0, dsum[25:0]};
      end else if (cmd.wrap) begin
         acc_ff[0] <= {1'b0, wrap_t[25:0]};
         acc_ff[1] <= acc_ff[1] + 27'(wrap_t[31:26]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul_en;
         if (cmd.out_write) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         msg_ff <= padded;
         top_ff <= full;
      end
      if (cmd.load) begin
         for (int i = 0; i < NUM_LIMBS - 1; i++) begin
            h_ff[i] <= 28'(acc_ff[i]) + 28'(ml[i]);
         end
         h_ff[4] <= 28'(acc_ff[4]) + {3'b000, top_ff, ml[4][HIBIT_POS-1:0]};
         for (int i = 0; i < NUM_LIMBS; i++) begin
            r_ff[i]  <= rc[i];
            s5_ff[i] <= (29'(rc[i]) << 2) + 29'(rc[i]);
         end
      end
      if (cmd.mul_en) begin
         for (int i = 0; i < NUM_LIMBS; i++) begin
            prod_ff[i] <= 57'(h_ff[i]) * 57'(coef[i]);
         end
         prod_col_ff <= cmd.mul_col;
      end
      if (prod_vld_ff) begin
         carry_ff <= dsum[57:26];
      end
      if (cmd.fin1) begin
         fin_ff[0] <= 27'(t0[25:0]);
         fin_ff[1] <= 27'(a1[25:0]) + 27'(c0);
         fin_ff[2] <= 27'(t2[25:0]);
         fin_ff[3] <= 27'(t3[25:0]);
         fin_ff[4] <= 27'(t4[25:0]);
      end
      if (cmd.fin2) begin
         lo_ff <= lo_c;
         hi_ff <= hi_c;
      end
      if (cmd.out_write) begin
         tag_low_ff  <= cmd.out_bad ? '0 : sum_lo[63:0];
         tag_high_ff <= cmd.out_bad ? '0 : sum_hi;
         bad_ff      <= cmd.out_bad;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tag_low   = tag_low_ff;
   assign rsp_tag_high  = tag_high_ff;
   assign rsp_bad_input = bad_ff;

endmodule

`default_nettype wire

@@ design/poly1305_mac_unit.sv @@
// Poly1305 one-time authenticator over 16-byte blocks (RFC 8439), top level.
// Instantiates p1305_ctrl and p1305_dp; depends on p1305_pkg.
//
// One block per beat, one block at a time. A full block runs, in order: the
// load of acc+block and the clamped r, five column steps through the
// five-lane 28x29 multiplier (one output limb per cycle), the sum of the last
// column and the carry wrap; req_ready returns after the wrap. A last beat
// then adds final reduction, s addition and tag write (a zero byte count goes
// straight to final reduction), and the tag write waits for the result
// register to free. A short non-last beat returns bad_input once the result
// register is free. The result sits in an output register; the user must write
// the key registers through the csr port only while the unit is idle; the unit
// itself does not enforce this.
`default_nettype none

module poly1305_mac_unit (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_wr_en,
   input  wire  [p1305_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [p1305_pkg::KEY_W-1:0]     csr_wdata,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [63:0]                     req_block_low,
   input  wire  [63:0]                     req_block_high,
   input  wire  [4:0]                      req_byte_count,
   input  wire                             req_is_last,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [63:0]                     rsp_tag_low,
   output logic [63:0]                     rsp_tag_high,
   output logic                            rsp_bad_input
);
   import p1305_pkg::*;

   cmd_type    cmd;
   status_type sts;

   p1305_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_count (req_byte_count),
      .req_is_last    (req_is_last),
      .cmd            (cmd),
      .sts            (sts)
   );

   p1305_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_block_low  (req_block_low),
      .req_block_high (req_block_high),
      .req_byte_count (req_byte_count),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_tag_low    (rsp_tag_low),
      .rsp_tag_high   (rsp_tag_high),
      .rsp_bad_input  (rsp_bad_input)
   );

endmodule

`default_nettype wire

@@ design/p1305_chk.sv @@
// Port-level checker for poly1305_mac_unit, with its bind.
// Depends on poly1305_mac_unit port names only.
`default_nettype none

module p1305_chk (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [63:0] rsp_tag_low,
   input wire [63:0] rsp_tag_high,
   input wire        rsp_bad_input
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tag_low)
         && $stable(rsp_tag_high) && $stable(rsp_bad_input))
      else $error("rsp beat dropped or changed under stall");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_input |-> rsp_tag_low == '0 && rsp_tag_high == '0)
      else $error("bad_input beat carries a nonzero tag");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while previous block in flight");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind poly1305_mac_unit p1305_chk u_p1305_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_tag_low   (rsp_tag_low),
   .rsp_tag_high  (rsp_tag_high),
   .rsp_bad_input (rsp_bad_input)
);

`default_nettype wire
